// ----- rtl/core/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the colour fade stepper: channel widths,
// beat payload layouts and the register map of the configuration port.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // Colour and channel geometry (GRB packing: green 23:16, red 15:8, blue 7:0).
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int PROD_W  = 2 * CH_W;

    // Configuration port geometry.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from paddr bit 2.
    localparam logic REG_START_COLOR = 1'b0;
    localparam logic REG_END_COLOR   = 1'b1;

    // Payload of one input beat.
    typedef struct packed {
        logic restart;
    } tick_t;

    // Payload of one output beat.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CH_W-1:0]    step_index;
        logic [CH_W-1:0]    step_total;
        logic               is_last;
        logic               finished;
    } step_t;

    // Absolute difference of two channel values.
    function automatic logic [CH_W-1:0] ch_absdiff(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
        logic [CH_W-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

endpackage

// ----- rtl/core/cfs_stream_if.sv -----
// ----------------------------------------------------------------------------
// cfs_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface cfs_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ----- rtl/core/cfs_apb_regs.sv -----
// ----------------------------------------------------------------------------
// cfs_apb_regs
// APB-style register file holding the fade start and end colours.
// ----------------------------------------------------------------------------
module cfs_apb_regs
    import cfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [COLOR_W-1:0] start_color,
    output logic [COLOR_W-1:0] end_color
);

    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] end_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes, decoded on address bit 2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_START_COLOR: start_reg <= pwdata[COLOR_W-1:0];
                REG_END_COLOR:   end_reg   <= pwdata[COLOR_W-1:0];
                default:         start_reg <= start_reg;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (paddr[2])
            REG_START_COLOR: prdata = {{(DATA_W-COLOR_W){1'b0}}, start_reg};
            REG_END_COLOR:   prdata = {{(DATA_W-COLOR_W){1'b0}}, end_reg};
            default:         prdata = '0;
        endcase
    end

    assign start_color = start_reg;
    assign end_color   = end_reg;

endmodule

// ----- rtl/core/cfs_divider.sv -----
// ----------------------------------------------------------------------------
// cfs_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in one channel width (dividend < divisor << CH_W).
// ----------------------------------------------------------------------------
module cfs_divider
    import cfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [CH_W-1:0]   divisor,
    output logic              done,
    output logic [CH_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(CH_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CH_W-1:0]  rem_reg;
    logic [CH_W-1:0]  rem_next;
    logic [CH_W-1:0]  dq_reg;
    logic [CH_W-1:0]  dq_next;
    logic [CH_W-1:0]  div_reg;
    logic [CH_W:0]    trial;
    logic             q_bit;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[CH_W-1]};
        q_bit    = (trial >= {1'b0, div_reg});
        rem_next = q_bit ? CH_W'(trial - {1'b0, div_reg}) : trial[CH_W-1:0];
        dq_next  = {dq_reg[CH_W-2:0], q_bit};
    end

    // Control: busy flag and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CH_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:CH_W];
            dq_reg  <= dividend[CH_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(CH_W - 1));
    assign quotient = dq_next;

endmodule

// ----- rtl/core/color_fade_stepper.sv -----
// ----------------------------------------------------------------------------
// color_fade_stepper
// Steps a linear fade between two GRB colours, one step per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Program start_color (address 0) and end_color (address 4) over the APB
//   port while the block is idle. Each beat on the tick channel (restart = 1
//   starts again at step zero, restart = 0 advances) yields exactly one beat
//   on the step channel carrying the colour, step index, step count N,
//   a last-step flag and a finished flag.
// Operation:
//   A stepping beat runs the three channels in turn through one shared 8x8
//   multiplier and one shared bit-serial divider (per channel: multiply,
//   load the divider, then divide); its result goes to the output register
//   once blue is done. A beat that finds the fade done (or N = 0) skips the
//   multiply and divide and goes straight to the output register.
//   tick.ready is low while a beat is worked on.
// Reset and stalls:
//   Reset clears both colours, the step counter and the held colour. A
//   result waits in the output register while the receiver stalls; the next
//   tick may be taken meanwhile, but its result waits until the slot frees.
// ----------------------------------------------------------------------------
module color_fade_stepper
    import cfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    cfs_stream_if.sink        tick,
    cfs_stream_if.source      step
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    // Channel codes, in processing order.
    localparam logic [1:0] CH_GREEN = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;

    logic [1:0]         state_reg;
    logic [1:0]         ch_reg;
    logic [CH_W-1:0]    counter_reg;
    logic [CH_W-1:0]    idx_reg;
    logic [COLOR_W-1:0] held_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               div_start_reg;
    step_t              res_reg;
    step_t              out_reg;
    logic               out_valid_reg;

    logic [CH_W-1:0]    n_gr;
    logic [CH_W-1:0]    n_rb;
    logic [CH_W-1:0]    n_steps;
    logic [CH_W-1:0]    idx;
    logic [CH_W-1:0]    s_ch;
    logic [CH_W-1:0]    e_ch;
    logic [CH_W-1:0]    mag;
    logic [CH_W-1:0]    ch_value;
    logic [CH_W-1:0]    quotient;
    logic               div_done;
    logic               tick_fire;
    logic               out_load;

    cfs_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start_color (start_color),
        .end_color   (end_color)
    );

    cfs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (res_reg.step_total),
        .done     (div_done),
        .quotient (quotient)
    );

    // Step count N: largest absolute channel difference.
    always_comb
    begin
        n_gr    = ch_absdiff(start_color[23:16], end_color[23:16]);
        n_rb    = ch_absdiff(start_color[15:8], end_color[15:8]);
        if (n_rb > n_gr)
        begin
            n_gr = n_rb;
        end
        n_rb    = ch_absdiff(start_color[7:0], end_color[7:0]);
        n_steps = (n_rb > n_gr) ? n_rb : n_gr;
    end

    // Operands of the channel being worked on.
    always_comb
    begin
        case (ch_reg)
            CH_GREEN:
            begin
                s_ch = start_color[23:16];
                e_ch = end_color[23:16];
            end
            CH_RED:
            begin
                s_ch = start_color[15:8];
                e_ch = end_color[15:8];
            end
            default:
            begin
                s_ch = start_color[7:0];
                e_ch = end_color[7:0];
            end
        endcase
        mag      = ch_absdiff(s_ch, e_ch);
        ch_value = (e_ch >= s_ch) ? (s_ch + quotient) : (s_ch - quotient);
    end

    assign idx        = tick.payload.restart ? '0 : counter_reg;
    assign tick.ready = (state_reg == S_IDLE);
    assign tick_fire  = tick.valid & tick.ready;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || step.ready);

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_GREEN;
            counter_reg   <= '0;
            held_reg      <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick_fire)
                    begin
                        if ((n_steps == '0) || (idx >= n_steps))
                        begin
                            counter_reg <= idx;
                            state_reg   <= S_EMIT;
                        end
                        else
                        begin
                            counter_reg <= idx + 1'b1;
                            ch_reg      <= CH_GREEN;
                            state_reg   <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (ch_reg == CH_BLUE)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        held_reg  <= res_reg.color;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result assembly: header fields at the decision, colour per channel.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            idx_reg <= idx;
            if (n_steps == '0)
            begin
                res_reg <= '{color: start_color, step_index: '0, step_total: '0,
                             is_last: 1'b0, finished: 1'b1};
            end
            else if (idx >= n_steps)
            begin
                res_reg <= '{color: held_reg, step_index: '0, step_total: n_steps,
                             is_last: 1'b0, finished: 1'b1};
            end
            else
            begin
                res_reg.step_index <= idx;
                res_reg.step_total <= n_steps;
                res_reg.is_last    <= ({1'b0, idx} + 9'd1) == {1'b0, n_steps};
                res_reg.finished   <= 1'b0;
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= mag * idx_reg;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            case (ch_reg)
                CH_GREEN: res_reg.color[23:16] <= ch_value;
                CH_RED:   res_reg.color[15:8]  <= ch_value;
                default:  res_reg.color[7:0]   <= ch_value;
            endcase
        end
    end

    // Output register towards the step channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (step.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign step.valid   = out_valid_reg;
    assign step.payload = out_reg;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: colour fade stepper regression
// Drives tick beats into color_fade_stepper and programmes both colours over
// the APB port. A scoreboard model of the fade predicts every step beat, and
// each beat taken from the step channel is compared with it field by field.
// Both channels idle at random, and the register values are read back.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    localparam int TICK_TARGET   = 1550;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cfs_stream_if #(.payload_t(tick_t)) tick_ch ();
    cfs_stream_if #(.payload_t(step_t)) step_ch ();

    color_fade_stepper uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .step    (step_ch)
    );

    // Scoreboard copy of the registers and of the fade state.
    logic [COLOR_W-1:0] cfg_start;
    logic [COLOR_W-1:0] cfg_end;
    logic [8:0]         fade_pos;
    logic [COLOR_W-1:0] held;

    step_t expected_steps[$];

    int  err_count;
    int  ticks_sent;
    int  steps_checked;
    int  settings_used;
    int  quiet_cycles;
    bit  tick_slack;
    bit  step_slack;

    // Clock: 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Number of fade steps: the largest absolute channel difference.
    function automatic logic [CH_W-1:0] fade_steps(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        logic [CH_W-1:0] n;
        logic [CH_W-1:0] ca;
        logic [CH_W-1:0] cb;
        logic [CH_W-1:0] d;
        n = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            ca = a[ch*CH_W +: CH_W];
            cb = b[ch*CH_W +: CH_W];
            d  = (ca > cb) ? ca - cb : cb - ca;
            if (d > n)
                n = d;
        end
        return n;
    endfunction

    // One channel of step i out of n, quotient truncated toward zero.
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] s,
                                                 input logic [CH_W-1:0] e,
                                                 input int unsigned i,
                                                 input int unsigned n);
        int unsigned span;
        int unsigned q;
        if (e >= s)
        begin
            span = int'(e) - int'(s);
            q    = (span * i) / n;
            return s + q[CH_W-1:0];
        end
        span = int'(s) - int'(e);
        q    = (span * i) / n;
        return s - q[CH_W-1:0];
    endfunction

    // Works out the step beat that one tick beat causes and advances the state.
    function automatic step_t predict_step(input logic restart);
        step_t           r;
        logic [CH_W-1:0] n;
        if (restart)
            fade_pos = '0;
        n = fade_steps(cfg_start, cfg_end);
        r = '0;
        r.step_total = n;
        if (n == 0)
        begin
            held       = cfg_start;
            r.color    = cfg_start;
            r.finished = 1'b1;
        end
        else if (fade_pos >= n)
        begin
            r.color    = held;
            r.finished = 1'b1;
        end
        else
        begin
            for (int ch = 0; ch < 3; ch++)
                r.color[ch*CH_W +: CH_W] = blend_ch(cfg_start[ch*CH_W +: CH_W],
                                                    cfg_end[ch*CH_W +: CH_W],
                                                    32'(fade_pos), 32'(n));
            r.step_index = fade_pos[CH_W-1:0];
            r.is_last    = (fade_pos + 9'd1 == {1'b0, n});
            held         = r.color;
            fade_pos     = fade_pos + 9'd1;
        end
        return r;
    endfunction

    function automatic int draw_gap(input bit slack);
        return slack ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    // Sends one tick beat after a random gap and records what it should cause.
    task automatic send_tick(input logic restart);
        int gap;
        gap = draw_gap(tick_slack);
        @(negedge clk);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.payload.restart <= restart;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        expected_steps.push_back(predict_step(restart));
        ticks_sent++;
    endtask

    // Lowers the tick channel and waits until every step beat has come back.
    task automatic wait_quiet();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_START_COLOR)
            cfg_start = data[COLOR_W-1:0];
        else
            cfg_end = data[COLOR_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input logic idx, output logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        err_count++;
    endtask

    // Programmes both colours with random upper bits, then reads them back.
    task automatic set_colours(input logic [COLOR_W-1:0] s, input logic [COLOR_W-1:0] e);
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] rd;
        junk = $urandom();
        write_reg(REG_START_COLOR, {junk[31:24], s});
        junk = $urandom();
        write_reg(REG_END_COLOR, {junk[31:24], e});
        read_reg(REG_START_COLOR, rd);
        if (rd !== {8'h00, cfg_start})
            report("start_color readback", {8'h00, cfg_start}, rd);
        read_reg(REG_END_COLOR, rd);
        if (rd !== {8'h00, cfg_end})
            report("end_color readback", {8'h00, cfg_end}, rd);
        settings_used++;
    endtask

    // Receiver: stalls a random number of cycles before taking each step beat.
    initial
    begin : step_receiver
        int stall;
        step_ch.ready = 1'b0;
        forever
        begin
            stall = draw_gap(step_slack);
            @(negedge clk);
            if (stall > 0)
            begin
                step_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            step_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && step_ch.valid));
        end
    end

    // Compares each step beat taken with the oldest expectation.
    always @(posedge clk)
    begin : step_check
        step_t want;
        step_t got;
        if (rst_n && step_ch.valid && step_ch.ready)
        begin
            got = step_ch.payload;
            if (expected_steps.size() == 0)
            begin
                $display("%0t: step beat with nothing expected, actual %0h", $time, got);
                err_count++;
            end
            else
            begin
                want = expected_steps.pop_front();
                steps_checked++;
                if (got.color !== want.color)
                    report("color", 32'(want.color), 32'(got.color));
                if (got.step_index !== want.step_index)
                    report("step_index", 32'(want.step_index), 32'(got.step_index));
                if (got.step_total !== want.step_total)
                    report("step_total", 32'(want.step_total), 32'(got.step_total));
                if (got.is_last !== want.is_last)
                    report("is_last", 32'(want.is_last), 32'(got.is_last));
                if (got.finished !== want.finished)
                    report("finished", 32'(want.finished), 32'(got.finished));
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (step_ch.valid && step_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d step beats still expected", $time,
                     expected_steps.size());
            $display("color_fade_stepper regression: fail");
            $finish;
        end
    end

    // Zero registers give equal colours; then a short fade from step zero
    // without any restart, running on into the finished state.
    task automatic test_reset_then_advance();
        send_tick(1'b0);
        wait_quiet();
        set_colours(24'h000000, 24'h030102);
        repeat (5) send_tick(1'b0);
    endtask

    // Equal non-zero colours finish at once and latch the start colour.
    task automatic test_equal_colours();
        wait_quiet();
        set_colours(24'hFFFFFF, 24'hFFFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Full-range fade, mixed directions and register changes mid-fade that
    // both shrink and grow the step count.
    task automatic test_mid_fade_changes();
        wait_quiet();
        set_colours(24'hFF00FF, 24'h00FF00);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        wait_quiet();
        set_colours(24'hFF00FF, 24'hFE01FE);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_quiet();
        set_colours(24'h10F080, 24'h80100F);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        wait_quiet();
        set_colours(24'h000000, 24'h000005);
        repeat (3) send_tick(1'b0);
    endtask

    // Random fades, mostly short and run to completion, with stray restarts,
    // end colour changes mid-fade and random idling on both channels.
    task automatic test_random_fades();
        int                 phase;
        int                 kind;
        int                 len;
        int                 ch_val;
        logic [COLOR_W-1:0] s;
        logic [COLOR_W-1:0] e;
        logic [DATA_W-1:0]  word;
        phase = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            kind = $urandom_range(0, 17);
            s    = COLOR_W'($urandom());
            e    = s;
            if (phase < 2)
            begin
                s = (phase == 0) ? 24'h000000 : 24'hFFFFFF;
                e = ~s;
            end
            else if (kind < 14)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    ch_val = int'(s[ch*CH_W +: CH_W]) + int'($urandom_range(0, 48)) - 24;
                    if (ch_val < 0)
                        ch_val = 0;
                    if (ch_val > 255)
                        ch_val = 255;
                    e[ch*CH_W +: CH_W] = ch_val[CH_W-1:0];
                end
            end
            else if (kind < 16)
                e = COLOR_W'($urandom());
            tick_slack = ($urandom_range(0, 2) != 0);
            step_slack = ($urandom_range(0, 2) != 0);
            wait_quiet();
            set_colours(s, e);
            if (phase < 2 || $urandom_range(0, 7) != 0)
                send_tick(1'b1);
            len = int'(fade_steps(s, e)) + int'($urandom_range(1, 3));
            for (int k = 0; k < len && ticks_sent < TICK_TARGET; k++)
            begin
                if (k == len / 2 && phase >= 2 && $urandom_range(0, 4) == 0)
                begin
                    wait_quiet();
                    word = $urandom();
                    write_reg(REG_END_COLOR, word);
                end
                send_tick($urandom_range(0, 39) == 0);
            end
            phase++;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.payload = '0;
        cfg_start       = '0;
        cfg_end         = '0;
        fade_pos        = '0;
        held            = '0;
        err_count       = 0;
        ticks_sent      = 0;
        steps_checked   = 0;
        settings_used   = 0;
        quiet_cycles    = 0;
        tick_slack      = 1'b1;
        step_slack      = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_then_advance();
        test_equal_colours();
        test_mid_fade_changes();
        test_random_fades();

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d tick beats over %0d colour settings, checked %0d step beats.",
                 ticks_sent, settings_used, steps_checked);
        $display("Covered full-range and short fades, restarts and mid-fade changes: %0d errors.",
                 err_count);
        if (err_count == 0)
            $display("color_fade_stepper regression: pass");
        else
            $display("color_fade_stepper regression: fail");
        $finish;
    end

endmodule
